FILE: design/base64_stream_encoder_assert.svh
// Assertion macros for the base64 stream encoder.
// Expects signals named clk and rst in the including module.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// same-cycle implication
`define B64E_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define B64E_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/b64e_pkg.sv
// Shared types, constants and the sextet-to-character map for the encoder.
// No dependencies.
package b64e_pkg;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  localparam logic [6:0] PAD_CHAR = 7'h3D;

  typedef enum logic [1:0] {
    POS_0 = 2'd0,
    POS_1 = 2'd1,
    POS_2 = 2'd2
  } b64e_pos_t;

  // one queue word: up to four characters from a single input byte
  typedef struct packed {
    logic [1:0]      last_idx;
    logic            end_flag;
    logic [3:0][6:0] chars;
  } b64e_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64e_q_status_t;

  function automatic logic [6:0] b64e_char(input logic [5:0] v);
    logic [6:0] c;
    case (v) inside
      [6'd0:6'd25]:  c = 7'(v) + 7'd65;
      [6'd26:6'd51]: c = 7'(v) + 7'd71;
      [6'd52:6'd61]: c = 7'(v) - 7'd4;
      6'd62:         c = 7'h2B;
      default:       c = 7'h2F;
    endcase
    return c;
  endfunction

endpackage

FILE: design/b64e_queue.sv
// Small word queue between front and back of the encoder.
// Depends on b64e_pkg.
module b64e_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  b64e_pkg::b64e_entry_t  wr_entry,
  input  logic                   pop,
  output b64e_pkg::b64e_entry_t  head,
  output b64e_pkg::b64e_q_status_t status
);

  b64e_pkg::b64e_entry_t entries [b64e_pkg::Q_DEPTH];
  logic [b64e_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [b64e_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [b64e_pkg::Q_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head         = entries[rd_ptr];
  assign status.full  = (count == b64e_pkg::Q_CNT_W'(b64e_pkg::Q_DEPTH));
  assign status.empty = (count == '0);

endmodule

FILE: design/b64e_front.sv
// Front end: accepts bytes, tracks group position and leftover bits,
// and builds one queue word of characters per byte. Depends on b64e_pkg.
module b64e_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            in_byte,
  input  logic                  final_byte,
  output b64e_pkg::b64e_entry_t entry
);

  b64e_pkg::b64e_pos_t pos, pos_next;
  logic [3:0] leftover, leftover_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= b64e_pkg::POS_0;
      leftover <= '0;
    end else if (take) begin
      pos      <= pos_next;
      leftover <= leftover_next;
    end
  end

  // next group position and leftover bits
  always_comb begin
    pos_next      = b64e_pkg::POS_0;
    leftover_next = '0;
    if (!final_byte) begin
      case (pos)
        b64e_pkg::POS_1: begin
          pos_next      = b64e_pkg::POS_2;
          leftover_next = in_byte[3:0];
        end
        b64e_pkg::POS_2: begin
          pos_next      = b64e_pkg::POS_0;
          leftover_next = '0;
        end
        default: begin
          pos_next      = b64e_pkg::POS_1;
          leftover_next = {2'b00, in_byte[1:0]};
        end
      endcase
    end
  end

  // characters for this byte
  always_comb begin
    entry.chars    = {4{b64e_pkg::PAD_CHAR}};
    entry.last_idx = 2'd0;
    entry.end_flag = 1'b0;
    case (pos)
      b64e_pkg::POS_1: begin
        entry.chars[0] = b64e_pkg::b64e_char({leftover[1:0], in_byte[7:4]});
        entry.chars[1] = b64e_pkg::b64e_char({in_byte[3:0], 2'b00});
        if (final_byte) begin
          entry.last_idx = 2'd2;
          entry.end_flag = 1'b1;
        end
      end
      b64e_pkg::POS_2: begin
        entry.chars[0] = b64e_pkg::b64e_char({leftover, in_byte[7:6]});
        entry.chars[1] = b64e_pkg::b64e_char(in_byte[5:0]);
        entry.last_idx = 2'd1;
        entry.end_flag = final_byte;
      end
      default: begin
        entry.chars[0] = b64e_pkg::b64e_char(in_byte[7:2]);
        entry.chars[1] = b64e_pkg::b64e_char({in_byte[1:0], 4'b0000});
        if (final_byte) begin
          entry.last_idx = 2'd3;
          entry.end_flag = 1'b1;
        end
      end
    endcase
  end

endmodule

FILE: design/b64e_emit.sv
// Back end: walks the head queue word into the output register, one character
// per cycle while the output is not stalled. Depends on b64e_pkg and the assertion header.
`include "base64_stream_encoder_assert.svh"

module b64e_emit (
  input  logic                  clk,
  input  logic                  rst,
  input  b64e_pkg::b64e_entry_t head,
  input  logic                  q_empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [6:0]            out_char,
  output logic                  end_of_output
);

  logic [1:0] idx;
  logic       load;
  logic       head_last;

  assign load      = !q_empty && (!out_valid || out_ready);
  assign head_last = (idx == head.last_idx);
  assign pop       = load && head_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= head_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char      <= head.chars[idx];
      end_of_output <= head_last && head.end_flag;
    end
  end

  `B64E_ASSERT_IMP(a_idx_in_word, !q_empty, idx <= head.last_idx, "char index past word end")
  `B64E_ASSERT_IMP(a_idx_idle, q_empty, idx == 2'd0, "char index not at start while queue empty")
  `B64E_ASSERT_NXT(a_load_shows, load, out_valid, "loaded char not presented")

endmodule

FILE: design/base64_stream_encoder.sv
// Top level of the streaming base64 encoder: front, word queue, back.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_emit.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   input   | in_valid in_ready in_byte final_byte | in
//   output  | out_valid out_ready out_char         | out
//           |   end_of_output                      |
//
// One character leaves per cycle at most; a byte yields 1 or 2 characters
// (3 on a final byte at position 1, 4 on a final byte at group start),
// 4/3 on average.
// Bytes enter one per cycle while the 4-word queue has room; the output
// character register sets the sustained rate.
// Synchronous reset clears group position, queue and output valid.
// A stalled output fills the queue, then in_ready drops.
module base64_stream_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       end_of_output
);

  b64e_pkg::b64e_entry_t    entry;
  b64e_pkg::b64e_entry_t    head;
  b64e_pkg::b64e_q_status_t q_status;
  logic                     take;
  logic                     pop;

  assign in_ready = !q_status.full;
  assign take     = in_valid && in_ready;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .in_byte    (in_byte),
    .final_byte (final_byte),
    .entry      (entry)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (take),
    .wr_entry (entry),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  b64e_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_status.empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .end_of_output (end_of_output)
  );

endmodule

FILE: tb/sv/base64_stream_encoder_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for base64_stream_encoder: directed and random messages,
// random gaps on the input side and random stalls on the output side.
// Depends on b64e_pkg and the encoder RTL.
module base64_stream_encoder_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_BYTES = 140;
  localparam int MAX_REPORTS = 40;
  localparam logic [6:0] CH_UPPER_A = 7'h41;
  localparam logic [6:0] CH_LOWER_A = 7'h61;
  localparam logic [6:0] CH_DIGIT_0 = 7'h30;
  localparam logic [6:0] CH_PLUS = 7'h2B;
  localparam logic [6:0] CH_SLASH = 7'h2F;

  typedef struct packed {
    logic [6:0] ch;
    logic       eom;
  } b64_char_t;

  // Tracks the group position and carried bits, and holds the characters still owed.
  class b64_scoreboard;
    b64e_pkg::b64e_pos_t grp_pos;
    logic [3:0] carry_bits;
    b64_char_t owed_chars[$];
    int mismatches;
    int bytes_seen;
    int chars_seen;
    int messages;
    int final_at[3];

    function new();
      grp_pos = b64e_pkg::POS_0;
      carry_bits = '0;
      mismatches = 0;
      bytes_seen = 0;
      chars_seen = 0;
      messages = 0;
      final_at = '{0, 0, 0};
    endfunction

    function logic [6:0] sextet_ascii(logic [5:0] v);
      if (v < 6'd26) return CH_UPPER_A + 7'(v);
      else if (v < 6'd52) return CH_LOWER_A + 7'(v - 6'd26);
      else if (v < 6'd62) return CH_DIGIT_0 + 7'(v - 6'd52);
      else if (v == 6'd62) return CH_PLUS;
      return CH_SLASH;
    endfunction

    function void owe(logic [6:0] ch, logic eom);
      b64_char_t c;
      c.ch = ch;
      c.eom = eom;
      owed_chars.push_back(c);
    endfunction

    function void restart_group();
      grp_pos = b64e_pkg::POS_0;
      carry_bits = '0;
      messages++;
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      bytes_seen++;
      if (fin) final_at[grp_pos]++;
      case (grp_pos)
        b64e_pkg::POS_1: begin
          owe(sextet_ascii({carry_bits[1:0], b[7:4]}), 1'b0);
          if (fin) begin
            owe(sextet_ascii({b[3:0], 2'b00}), 1'b0);
            owe(b64e_pkg::PAD_CHAR, 1'b1);
            restart_group();
          end else begin
            carry_bits = b[3:0];
            grp_pos = b64e_pkg::POS_2;
          end
        end
        b64e_pkg::POS_2: begin
          owe(sextet_ascii({carry_bits, b[7:6]}), 1'b0);
          owe(sextet_ascii(b[5:0]), fin);
          // group is complete either way; only a final byte ends the message
          grp_pos = b64e_pkg::POS_0;
          carry_bits = '0;
          if (fin) messages++;
        end
        default: begin
          owe(sextet_ascii(b[7:2]), 1'b0);
          if (fin) begin
            owe(sextet_ascii({b[1:0], 4'b0000}), 1'b0);
            owe(b64e_pkg::PAD_CHAR, 1'b0);
            owe(b64e_pkg::PAD_CHAR, 1'b1);
            restart_group();
          end else begin
            carry_bits = {2'b00, b[1:0]};
            grp_pos = b64e_pkg::POS_1;
          end
        end
      endcase
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_char(logic [6:0] ch, logic eom);
      b64_char_t want;
      chars_seen++;
      if (owed_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h end=%0b", ch, eom));
      end else begin
        want = owed_chars.pop_front();
        if (ch !== want.ch)
          report_mismatch($sformatf("char %0d: out_char 0x%02h, want 0x%02h",
                                    chars_seen, ch, want.ch));
        if (eom !== want.eom)
          report_mismatch($sformatf("char %0d: end_of_output %0b, want %0b",
                                    chars_seen, eom, want.eom));
      end
    endtask

    function int pending();
      return owed_chars.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = '0;
  logic       final_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] out_char;
  logic       end_of_output;

  b64_scoreboard sb;
  bit steady = 1'b0;
  int cycles = 0;

  base64_stream_encoder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .final_byte(final_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char(out_char),
    .end_of_output(end_of_output)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d chars still owed", cycles, sb.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // input noted before output so a same-edge pair is ordered
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(in_byte, final_byte);
      if (out_valid && out_ready) sb.check_char(out_char, end_of_output);
    end
  end

  // mostly short gaps, a few long ones, none during steady stretches
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(0, 2);
    if (r < 19) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  initial begin : ready_driver
    int run_len;
    int stall;
    while (rst) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      run_len = steady ? $urandom_range(8, 32) : $urandom_range(1, 8);
      repeat (run_len) @(posedge clk);
      stall = idle_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [7:0] random_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : stimulus
    int msg_len[8];
    logic [7:0] dir_bytes[24];
    int idx;
    int sent;
    int len;
    int r;

    msg_len = '{1, 1, 2, 2, 3, 3, 7, 5};
    dir_bytes = '{
      8'h00,
      8'hFF,
      8'h00, 8'hFF,
      8'hFF, 8'h00,
      8'h4D, 8'h61, 8'h6E,
      8'hFB, 8'hFF, 8'hBF,
      8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h80,
      8'h01, 8'h02, 8'h03, 8'h04, 8'h05
    };

    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, messages ending at each group position, all-sextet bytes
    idx = 0;
    for (int m = 0; m < 8; m++) begin
      for (int k = 0; k < msg_len[m]; k++) begin
        send_byte(dir_bytes[idx], k == msg_len[m] - 1);
        idx++;
      end
    end

    // random messages, mostly short, a few spanning many groups
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 5) == 0) steady = ~steady;
      r = $urandom_range(0, 9);
      if (r < 7) len = $urandom_range(1, 6);
      else if (r < 9) len = $urandom_range(7, 12);
      else len = $urandom_range(13, 24);
      for (int k = 0; k < len; k++) send_byte(random_byte(), k == len - 1);
      sent += len;
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Encoded %0d bytes in %0d messages to %0d chars, %0d mismatches",
             sb.bytes_seen, sb.messages, sb.chars_seen, sb.mismatches);
    $display("Messages ended at group position 0/1/2: %0d/%0d/%0d",
             sb.final_at[0], sb.final_at[1], sb.final_at[2]);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
